// ===== src/h264sps_pkg.sv =====
package h264sps_pkg;

  localparam int MAX_LZ_DEFAULT = 32;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

// ===== src/h264_sps_resolution_parser.sv =====
// Channel  | Direction | Fields
// s_*      | in        | tdata: sps_byte[7:0]; tlast: last_byte
// m_*      | out       | tdata: status, width, height, profile, chroma_format, frame_only
//
// Each byte from the fifth on is taken from the queue and then fed bit by bit to the
// bit-serial Exp-Golomb unit; the first four are only taken from the queue.
// After the last byte, missing bits are read as zero one per cycle until the cropping
// fields are done; S_DRAIN sees the end, S_FIN1/S_FIN2 form the result, S_EMIT sends it.
// A four-entry queue parts the input from the parser; a result register parts the output.
// Synchronous reset clears the queue, the parser and m_tvalid, but not the result fields.
module h264_sps_resolution_parser #(
  parameter int MAX_LEADING_ZEROS = h264sps_pkg::MAX_LZ_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] sps_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[1:0], width[17:2], height[33:18],
                                // profile[41:34], chroma_format[43:42], frame_only[44]
);
  import h264sps_pkg::*;

  item_t   in_item;
  q_head_t head;
  logic    pop;

  assign in_item.data = s_tdata;
  assign in_item.last = s_tlast;

  h264sps_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  h264sps_back #(
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== src/h264sps_fifo.sv =====
module h264sps_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  h264sps_pkg::item_t    in_item,
  output h264sps_pkg::q_head_t  head,
  input  logic                  pop
);
  import h264sps_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push;
  logic               take;

  assign s_tready   = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(take);
    end
  end

endmodule

// ===== src/h264sps_back.sv =====
module h264sps_back #(
  parameter int MAX_LEADING_ZEROS = h264sps_pkg::MAX_LZ_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  h264sps_pkg::q_head_t  head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata
);
  import h264sps_pkg::*;

  typedef enum logic [30:0] {
    PH_SKIP          = 31'd1 << 0,
    PH_SPS_ID        = 31'd1 << 1,
    PH_CHROMA        = 31'd1 << 2,
    PH_SEP           = 31'd1 << 3,
    PH_DEPTH_L       = 31'd1 << 4,
    PH_DEPTH_C       = 31'd1 << 5,
    PH_BYPASS        = 31'd1 << 6,
    PH_SCALE_PRESENT = 31'd1 << 7,
    PH_LIST_FLAG     = 31'd1 << 8,
    PH_DELTA         = 31'd1 << 9,
    PH_FRAME_NUM     = 31'd1 << 10,
    PH_POC_TYPE      = 31'd1 << 11,
    PH_POC_LSB       = 31'd1 << 12,
    PH_POC_ZERO      = 31'd1 << 13,
    PH_POC_NONREF    = 31'd1 << 14,
    PH_POC_TB        = 31'd1 << 15,
    PH_POC_NUMREF    = 31'd1 << 16,
    PH_POC_OFFSET    = 31'd1 << 17,
    PH_MAX_REF       = 31'd1 << 18,
    PH_GAPS          = 31'd1 << 19,
    PH_WIDTH         = 31'd1 << 20,
    PH_HEIGHT        = 31'd1 << 21,
    PH_FRAME_ONLY    = 31'd1 << 22,
    PH_MBAFF         = 31'd1 << 23,
    PH_DIRECT        = 31'd1 << 24,
    PH_CROP_FLAG     = 31'd1 << 25,
    PH_CROP_L        = 31'd1 << 26,
    PH_CROP_R        = 31'd1 << 27,
    PH_CROP_T        = 31'd1 << 28,
    PH_CROP_B        = 31'd1 << 29,
    PH_DONE          = 31'd1 << 30
  } phase_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BITS  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_FIN1  = 6'b001000,
    S_FIN2  = 6'b010000,
    S_EMIT  = 6'b100000
  } ctl_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  function automatic logic is_high(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 || p == 8'd44 ||
           p == 8'd83 || p == 8'd86 || p == 8'd118 || p == 8'd128;
  endfunction

  function automatic logic is_flag(input phase_t ph);
    return ph == PH_SEP || ph == PH_BYPASS || ph == PH_SCALE_PRESENT ||
           ph == PH_LIST_FLAG || ph == PH_POC_ZERO || ph == PH_GAPS ||
           ph == PH_FRAME_ONLY || ph == PH_MBAFF || ph == PH_DIRECT ||
           ph == PH_CROP_FLAG;
  endfunction

  ctl_t         ctl;
  logic [2:0]   byte_idx;
  logic [7:0]   shreg;
  logic [2:0]   bit_cnt;
  logic         last_seen;
  status_t      res_status;
  logic signed [39:0] w_diff;
  logic signed [39:0] h_diff;

  phase_t       phase, phase_next;
  logic [5:0]   lz, lz_next;
  logic         in_suffix, in_suffix_next;
  logic [32:0]  acc, acc_next;
  logic [7:0]   profile, profile_next;
  logic [1:0]   chroma, chroma_next;
  logic [3:0]   list_idx, list_idx_next;
  logic [6:0]   coef_idx, coef_idx_next;
  logic [7:0]   scale_last, scale_last_next;
  logic [31:0]  ref_left, ref_left_next;
  logic [32:0]  width_mbs, width_mbs_next;
  logic [32:0]  height_units, height_units_next;
  logic         frame_only, frame_only_next;
  logic [32:0]  crop0, crop0_next;
  logic [32:0]  crop1, crop1_next;

  logic [1:0]   o_status;
  logic [15:0]  o_width;
  logic [15:0]  o_height;
  logic [7:0]   o_profile;
  logic [1:0]   o_chroma;
  logic         o_frame_only;

  logic         out_free;
  logic         emit;
  logic         feed_en;
  logic         fbit;
  logic         skip;
  logic         done;
  logic [32:0]  v;
  logic [32:0]  shifted;
  logic [7:0]   se;
  logic [7:0]   sn;
  logic [3:0]   li_inc;
  logic [3:0]   list_cnt;
  phase_t       phase_nl;
  logic [6:0]   coef_inc;
  logic [6:0]   coef_lim;
  logic [33:0]  sum34;
  logic [31:0]  rl;

  logic [36:0]  w16;
  logic [33:0]  cx;
  logic [37:0]  hb;
  logic [34:0]  c1y;
  logic         w_bad;
  logic         h_bad;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = (ctl == S_EMIT) && out_free;
  assign pop      = (ctl == S_IDLE) && head.valid;
  assign skip     = (ctl == S_DRAIN) && (phase == PH_POC_OFFSET) && !in_suffix && (lz == '0);
  assign feed_en  = (ctl == S_BITS) || ((ctl == S_DRAIN) && (phase != PH_DONE) && !skip);
  assign fbit     = (ctl == S_BITS) ? shreg[7] : 1'b0;

  always_comb begin
    phase_next        = phase;
    lz_next           = lz;
    in_suffix_next    = in_suffix;
    acc_next          = acc;
    profile_next      = profile;
    chroma_next       = chroma;
    list_idx_next     = list_idx;
    coef_idx_next     = coef_idx;
    scale_last_next   = scale_last;
    ref_left_next     = ref_left;
    width_mbs_next    = width_mbs;
    height_units_next = height_units;
    frame_only_next   = frame_only;
    crop0_next        = crop0;
    crop1_next        = crop1;
    done              = 1'b0;
    v                 = '0;
    shifted           = {acc[31:0], fbit};

    if (feed_en && phase != PH_SKIP && phase != PH_DONE) begin
      if (is_flag(phase)) begin
        v    = {32'd0, fbit};
        done = 1'b1;
      end else if (!in_suffix) begin
        if (!fbit && lz < 6'(MAX_LEADING_ZEROS)) begin
          lz_next = lz + 6'd1;
        end else if (lz == '0) begin
          acc_next = '0;
          done     = 1'b1;
        end else begin
          acc_next       = 33'd1;
          in_suffix_next = 1'b1;
        end
      end else begin
        lz_next = lz - 6'd1;
        if (lz == 6'd1) begin
          in_suffix_next = 1'b0;
          acc_next       = shifted - 33'd1;
          v              = shifted - 33'd1;
          done           = 1'b1;
        end else begin
          acc_next = shifted;
        end
      end
    end

    se       = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
    sn       = scale_last + se;
    li_inc   = list_idx + 4'd1;
    list_cnt = (chroma == 2'd3) ? 4'd12 : 4'd8;
    phase_nl = (li_inc >= list_cnt) ? PH_FRAME_NUM : PH_LIST_FLAG;
    coef_inc = coef_idx + 7'd1;
    coef_lim = (list_idx < 4'd6) ? 7'd16 : 7'd64;
    rl       = v[32] ? 32'hFFFF_FFFF : v[31:0];
    sum34    = 34'(crop0) + 34'(v);
    if (phase == PH_CROP_B) begin
      sum34 = 34'(crop1) + 34'(v);
    end

    if (done) begin
      unique case (phase)
        PH_SPS_ID: phase_next = is_high(profile) ? PH_CHROMA : PH_FRAME_NUM;
        PH_CHROMA: begin
          chroma_next = (v > 33'd3) ? 2'd3 : v[1:0];
          phase_next  = (chroma_next == 2'd3) ? PH_SEP : PH_DEPTH_L;
        end
        PH_SEP:     phase_next = PH_DEPTH_L;
        PH_DEPTH_L: phase_next = PH_DEPTH_C;
        PH_DEPTH_C: phase_next = PH_BYPASS;
        PH_BYPASS:  phase_next = PH_SCALE_PRESENT;
        PH_SCALE_PRESENT: begin
          list_idx_next = '0;
          phase_next    = v[0] ? PH_LIST_FLAG : PH_FRAME_NUM;
        end
        PH_LIST_FLAG: begin
          if (v[0]) begin
            coef_idx_next   = '0;
            scale_last_next = 8'd8;
            phase_next      = PH_DELTA;
          end else begin
            list_idx_next = li_inc;
            phase_next    = phase_nl;
          end
        end
        PH_DELTA: begin
          if (sn != 8'd0) begin
            scale_last_next = sn;
          end
          coef_idx_next = coef_inc;
          if (sn == 8'd0 || coef_inc >= coef_lim) begin
            list_idx_next = li_inc;
            phase_next    = phase_nl;
          end
        end
        PH_FRAME_NUM: phase_next = PH_POC_TYPE;
        PH_POC_TYPE: begin
          if (v == 33'd0) begin
            phase_next = PH_POC_LSB;
          end else if (v == 33'd1) begin
            phase_next = PH_POC_ZERO;
          end else begin
            phase_next = PH_MAX_REF;
          end
        end
        PH_POC_LSB:    phase_next = PH_MAX_REF;
        PH_POC_ZERO:   phase_next = PH_POC_NONREF;
        PH_POC_NONREF: phase_next = PH_POC_TB;
        PH_POC_TB:     phase_next = PH_POC_NUMREF;
        PH_POC_NUMREF: begin
          ref_left_next = rl;
          phase_next    = (rl != '0) ? PH_POC_OFFSET : PH_MAX_REF;
        end
        PH_POC_OFFSET: begin
          ref_left_next = ref_left - 32'd1;
          if (ref_left == 32'd1) begin
            phase_next = PH_MAX_REF;
          end
        end
        PH_MAX_REF: phase_next = PH_GAPS;
        PH_GAPS:    phase_next = PH_WIDTH;
        PH_WIDTH: begin
          width_mbs_next = v + 33'd1;
          phase_next     = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_units_next = v + 33'd1;
          phase_next        = PH_FRAME_ONLY;
        end
        PH_FRAME_ONLY: begin
          frame_only_next = v[0];
          phase_next      = v[0] ? PH_DIRECT : PH_MBAFF;
        end
        PH_MBAFF:     phase_next = PH_DIRECT;
        PH_DIRECT:    phase_next = PH_CROP_FLAG;
        PH_CROP_FLAG: phase_next = v[0] ? PH_CROP_L : PH_DONE;
        PH_CROP_L: begin
          crop0_next = v;
          phase_next = PH_CROP_R;
        end
        PH_CROP_R: begin
          crop0_next = sum34[33] ? '1 : sum34[32:0];
          phase_next = PH_CROP_T;
        end
        PH_CROP_T: begin
          crop1_next = v;
          phase_next = PH_CROP_B;
        end
        PH_CROP_B: begin
          crop1_next = sum34[33] ? '1 : sum34[32:0];
          phase_next = PH_DONE;
        end
        default: phase_next = PH_DONE;
      endcase
    end

    if (skip) begin
      ref_left_next = '0;
      phase_next    = PH_MAX_REF;
    end

    if (pop) begin
      if (byte_idx == 3'd1) begin
        profile_next = head.item.data;
      end
      if (byte_idx == 3'd3) begin
        phase_next = PH_SPS_ID;
      end
    end

    if (emit) begin
      phase_next        = PH_SKIP;
      lz_next           = '0;
      in_suffix_next    = 1'b0;
      acc_next          = '0;
      profile_next      = '0;
      chroma_next       = 2'd1;
      list_idx_next     = '0;
      coef_idx_next     = '0;
      scale_last_next   = 8'd8;
      ref_left_next     = '0;
      width_mbs_next    = '0;
      height_units_next = '0;
      frame_only_next   = 1'b0;
      crop0_next        = '0;
      crop1_next        = '0;
    end
  end

  always_comb begin
    w16 = {width_mbs, 4'd0};
    cx  = (chroma == 2'd1 || chroma == 2'd2) ? {crop0, 1'b0} : {1'b0, crop0};
    hb  = frame_only ? {1'b0, height_units, 4'd0} : {height_units, 5'd0};
    unique case ({chroma == 2'd1, !frame_only})
      2'b00:   c1y = {2'd0, crop1};
      2'b01,
      2'b10:   c1y = {1'b0, crop1, 1'b0};
      default: c1y = {crop1, 2'd0};
    endcase
    w_bad = w_diff[39] || (w_diff == '0) || (w_diff[38:16] != '0);
    h_bad = h_diff[39] || (h_diff == '0) || (h_diff[38:16] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SKIP;
      lz           <= '0;
      in_suffix    <= 1'b0;
      acc          <= '0;
      profile      <= '0;
      chroma       <= 2'd1;
      list_idx     <= '0;
      coef_idx     <= '0;
      scale_last   <= 8'd8;
      ref_left     <= '0;
      width_mbs    <= '0;
      height_units <= '0;
      frame_only   <= 1'b0;
      crop0        <= '0;
      crop1        <= '0;
    end else begin
      phase        <= phase_next;
      lz           <= lz_next;
      in_suffix    <= in_suffix_next;
      acc          <= acc_next;
      profile      <= profile_next;
      chroma       <= chroma_next;
      list_idx     <= list_idx_next;
      coef_idx     <= coef_idx_next;
      scale_last   <= scale_last_next;
      ref_left     <= ref_left_next;
      width_mbs    <= width_mbs_next;
      height_units <= height_units_next;
      frame_only   <= frame_only_next;
      crop0        <= crop0_next;
      crop1        <= crop1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= S_IDLE;
      byte_idx   <= '0;
      bit_cnt    <= '0;
      last_seen  <= 1'b0;
      res_status <= STAT_OK;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      unique case (ctl)
        S_IDLE: begin
          if (pop) begin
            if (byte_idx != 3'd4) begin
              byte_idx <= byte_idx + 3'd1;
            end
            if (byte_idx == 3'd4) begin
              shreg     <= head.item.data;
              bit_cnt   <= '0;
              last_seen <= head.item.last;
              ctl       <= S_BITS;
            end else if (head.item.last) begin
              res_status <= STAT_SHORT;
              ctl        <= S_EMIT;
            end
          end
        end
        S_BITS: begin
          shreg   <= {shreg[6:0], 1'b0};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            ctl <= last_seen ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          if (phase == PH_DONE) begin
            ctl <= S_FIN1;
          end
        end
        S_FIN1: begin
          w_diff <= signed'({3'd0, w16}) - signed'({6'd0, cx});
          h_diff <= signed'({2'd0, hb}) - signed'({5'd0, c1y});
          ctl    <= S_FIN2;
        end
        S_FIN2: begin
          res_status <= (w_bad || h_bad) ? STAT_RANGE : STAT_OK;
          ctl        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            o_status     <= res_status;
            o_width      <= (res_status == STAT_OK) ? w_diff[15:0] : 16'd0;
            o_height     <= (res_status == STAT_OK) ? h_diff[15:0] : 16'd0;
            o_profile    <= profile;
            o_chroma     <= chroma;
            o_frame_only <= frame_only;
            byte_idx     <= '0;
            ctl          <= S_IDLE;
          end
        end
        default: ctl <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {3'd0, o_frame_only, o_chroma, o_profile, o_height, o_width, o_status};

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status == STAT_OK) |-> (o_width != '0 && o_height != '0))
    else $error("ok result with zero dimension");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (ctl == S_IDLE))
    else $error("byte taken while busy");

  a_lz_bound: assert property (@(posedge clk) disable iff (rst)
    lz <= 6'(MAX_LEADING_ZEROS))
    else $error("leading zero count overrun");

endmodule
